// ===== rtl/keypad_scan_code_lock_core_defines.svh =====
// Assertion macros for the keypad scanner with code lock.
// Used by keypad_scan_code_lock_core; depends on a clock named clk and a reset named rst.
`ifndef KEYPAD_SCAN_CODE_LOCK_CORE_DEFINES_SVH
`define KEYPAD_SCAN_CODE_LOCK_CORE_DEFINES_SVH

// Property checked on every clock edge while out of reset.
`define KSCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define KSCL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kscl_pkg.sv =====
// Shared types and constants for the keypad scanner with code lock.
// No dependencies; imported by keypad_scan_code_lock_core, keypad_lock_checker and tb_top.
package kscl_pkg;

  // Scanner phases.
  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  // Configuration register indexes.
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_PASSCODE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [31:0] PASSCODE_RESET = 32'h3132_3334;

  // Packed result item, first field in the highest bits.
  typedef struct packed {
    logic       access_granted;
    logic       verdict_valid;
    logic [2:0] entry_length;
    logic [6:0] key_char;
    logic       key_valid;
    logic [3:0] row_drive;
  } result_t;

  // ASCII of the key at {row, column}.
  function automatic logic [6:0] key_ascii(input logic [3:0] idx);
    logic [6:0] ch;
    unique case (idx)
      4'd0:  ch = 7'h31; // 1
      4'd1:  ch = 7'h32; // 2
      4'd2:  ch = 7'h33; // 3
      4'd3:  ch = 7'h41; // A
      4'd4:  ch = 7'h34; // 4
      4'd5:  ch = 7'h35; // 5
      4'd6:  ch = 7'h36; // 6
      4'd7:  ch = 7'h42; // B
      4'd8:  ch = 7'h37; // 7
      4'd9:  ch = 7'h38; // 8
      4'd10: ch = 7'h39; // 9
      4'd11: ch = 7'h43; // C
      4'd12: ch = 7'h2A; // *
      4'd13: ch = 7'h30; // 0
      4'd14: ch = 7'h23; // #
      default: ch = 7'h44; // D
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/keypad_scan_code_lock_core.sv =====
// Each accepted scan tick's result is registered in the output register.
// One tick per cycle unless a result stalls; the output register refills as it is taken.
// The scanner state and the code comparison settle in one pass before the output register.
// Reset (rst, synchronous): row one, scanning, empty entry, debounce 20, passcode "1234".
// Depends on kscl_pkg and keypad_scan_code_lock_core_defines.svh.
`include "keypad_scan_code_lock_core_defines.svh"

module keypad_scan_code_lock_core
  import kscl_pkg::*;
#(
  parameter int CODE_LENGTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Scan tick input. tdata: [3:0] column_levels, [7:4] zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Result output. tdata: [3:0] row_drive, [4] key_valid, [11:5] key_char,
  // [14:12] entry_length, [15] verdict_valid, [16] access_granted, [23:17] zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] CodeLen = 4'(CODE_LENGTH);
  localparam logic [31:0] CodeMask = (CODE_LENGTH >= 4) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << (8 * CODE_LENGTH)) - 64'd1);

  // Configuration and scanner state.
  logic [15:0] debounce_ticks;
  logic [31:0] passcode;
  phase_t      phase, phase_next;
  logic [1:0]  scan_row, scan_row_next;
  logic [15:0] wait_count, wait_count_next;
  logic [1:0]  held_column, held_column_next;
  logic [6:0]  held_key, held_key_next;
  logic [2:0]  entered_count, entered_count_next;
  logic [31:0] entered_code, entered_code_next;

  // Output register.
  logic        out_valid;
  result_t     out_data;
  result_t     res;

  logic        in_fire;
  logic [3:0]  cols;
  logic [3:0]  pressed;
  logic [1:0]  press_col;
  logic [2:0]  count_inc;
  logic [31:0] code_shift;

  assign cols          = s_axis_tdata[3:0];
  assign pressed       = ~cols;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign count_inc     = entered_count + 3'd1;
  assign code_shift    = {entered_code[23:0], 1'b0, held_key};

  // Lowest pressed column wins.
  always_comb begin
    priority if (pressed[0]) press_col = 2'd0;
    else if (pressed[1])     press_col = 2'd1;
    else if (pressed[2])     press_col = 2'd2;
    else                     press_col = 2'd3;
  end

  // Next state and result of one tick.
  always_comb begin
    phase_next         = phase;
    scan_row_next      = scan_row;
    wait_count_next    = wait_count;
    held_column_next   = held_column;
    held_key_next      = held_key;
    entered_count_next = entered_count;
    entered_code_next  = entered_code;
    res                = '0;
    res.row_drive      = ~(4'b0001 << scan_row);
    unique case (phase)
      PH_DEBOUNCE: begin
        if (wait_count <= 16'd1) begin
          wait_count_next = '0;
          phase_next      = PH_RELEASE;
        end else begin
          wait_count_next = wait_count - 16'd1;
        end
      end
      PH_RELEASE: begin
        if (cols[held_column]) begin
          res.key_valid      = 1'b1;
          res.key_char       = held_key;
          entered_code_next  = code_shift;
          entered_count_next = count_inc;
          if ({1'b0, count_inc} >= CodeLen) begin
            res.verdict_valid  = 1'b1;
            res.access_granted = (code_shift & CodeMask) == (passcode & CodeMask);
            entered_count_next = '0;
            entered_code_next  = '0;
          end
          scan_row_next = '0;
          phase_next    = PH_SCAN;
        end
      end
      default: begin
        if (pressed != 4'd0) begin
          held_column_next = press_col;
          held_key_next    = key_ascii({scan_row, press_col});
          if (debounce_ticks == 16'd0) begin
            wait_count_next = '0;
            phase_next      = PH_RELEASE;
          end else begin
            wait_count_next = debounce_ticks;
            phase_next      = PH_DEBOUNCE;
          end
        end else begin
          scan_row_next = scan_row + 2'd1;
          phase_next    = PH_SCAN;
        end
      end
    endcase
    res.entry_length = entered_count_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      passcode       <= PASSCODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_ticks <= cfg_data[15:0];
        CFG_PASSCODE: passcode       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scanner state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SCAN;
      scan_row      <= '0;
      wait_count    <= '0;
      held_column   <= '0;
      held_key      <= '0;
      entered_count <= '0;
      entered_code  <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      scan_row      <= scan_row_next;
      wait_count    <= wait_count_next;
      held_column   <= held_column_next;
      held_key      <= held_key_next;
      entered_count <= entered_count_next;
      entered_code  <= entered_code_next;
    end
  end

  // Output register: loads on a new tick, empties when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_data};

  // A debounce wait always has ticks left to count.
  `KSCL_ASSERT(a_debounce_count, (phase == PH_DEBOUNCE) |-> (wait_count != 16'd0), "debounce phase with zero count")
  // A press seen while scanning leaves the scanning phase.
  `KSCL_ASSERT(a_press_leaves_scan, (in_fire && phase == PH_SCAN && cols != 4'hF) |=> (phase != PH_SCAN), "press did not start a key")
  // A verdict comes only with a key and always closes the entry.
  `KSCL_ASSERT(a_verdict_key, (out_valid && out_data.verdict_valid) |-> (out_data.key_valid && out_data.entry_length == 3'd0), "verdict without key or with open entry")
  // Nothing is accepted while the output register is full and stalled.
  `KSCL_ASSERT_ALWAYS(a_no_overrun, (out_valid && !m_axis_tready) |-> !s_axis_tready, "tick accepted over a stalled result")

endmodule

// ===== bench/keypad_lock_checker.sv =====
// Scoreboard for keypad_scan_code_lock_core: watches the scan, result and register channels.
// It predicts one result per accepted scan tick and compares each result field by field.
// Depends on kscl_pkg for the scanner phases, the register indexes and the result layout.
module keypad_lock_checker
  import kscl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  input  logic        tick_ready,
  input  logic [7:0]  tick_data,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [23:0] result_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          results_owed
);

  localparam int LOCK_LEN = 4;
  // Key legend in scan order, row one first; character i sits at bits [127-8*i -: 8].
  localparam logic [127:0] KEYPAD_LAYOUT = "123A456B789C*0#D";

  // Mirror of the scanner and lock state.
  logic [1:0]  row_q;
  phase_t      phase_q;
  logic [15:0] wait_q;
  logic [1:0]  col_q;
  logic [6:0]  key_q;
  logic [2:0]  count_q;
  logic [31:0] code_q;
  logic [15:0] debounce_q;
  logic [31:0] passcode_q;
  result_t     expected_results[$];

  // Advance the mirror by one scan tick and return the result that tick produces.
  function automatic result_t scan_tick(input logic [3:0] cols);
    result_t     r;
    logic [3:0]  pressed;
    logic [1:0]  col;
    logic [31:0] mask;
    r = '0;
    r.row_drive = ~(4'b0001 << row_q);
    case (phase_q)
      PH_DEBOUNCE: begin
        // Columns are ignored until the wait runs out.
        if (wait_q <= 16'd1) begin
          wait_q  = 16'd0;
          phase_q = PH_RELEASE;
        end else begin
          wait_q = wait_q - 16'd1;
        end
      end
      PH_RELEASE: begin
        if (cols[col_q]) begin
          r.key_valid = 1'b1;
          r.key_char  = key_q;
          code_q  = {code_q[23:0], 1'b0, key_q};
          count_q = count_q + 3'd1;
          if (count_q >= LOCK_LEN) begin
            mask = (LOCK_LEN >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * LOCK_LEN)) - 32'd1);
            r.verdict_valid  = 1'b1;
            r.access_granted = ((code_q & mask) == (passcode_q & mask));
            count_q = 3'd0;
            code_q  = 32'd0;
          end
          row_q   = 2'd0;
          phase_q = PH_SCAN;
        end
      end
      default: begin
        // Scanning, and any unused phase code behaves the same way.
        pressed = ~cols;
        if (pressed != 4'd0) begin
          col = 2'd0;
          for (int i = 3; i >= 0; i--) begin
            if (pressed[i]) col = i[1:0];
          end
          col_q = col;
          key_q = KEYPAD_LAYOUT[126 - 8 * {row_q, col} -: 7];
          if (debounce_q == 16'd0) begin
            wait_q  = 16'd0;
            phase_q = PH_RELEASE;
          end else begin
            wait_q  = debounce_q;
            phase_q = PH_DEBOUNCE;
          end
        end else begin
          row_q   = row_q + 2'd1;
          phase_q = PH_SCAN;
        end
      end
    endcase
    r.entry_length = count_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      row_q      = 2'd0;
      phase_q    = PH_SCAN;
      wait_q     = 16'd0;
      col_q      = 2'd0;
      key_q      = 7'd0;
      count_q    = 3'd0;
      code_q     = 32'd0;
      debounce_q = DEBOUNCE_RESET;
      passcode_q = PASSCODE_RESET;
      mismatches = 0;
      expected_results.delete();
    end else begin
      // Compare a result transaction with the oldest expectation.
      if (result_valid && result_ready) begin
        got = result_data[$bits(result_t)-1:0];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h with no scan tick waiting", result_data);
        end else begin
          want = expected_results.pop_front();
          if (got.row_drive !== want.row_drive || got.key_valid !== want.key_valid ||
              got.key_char !== want.key_char || got.entry_length !== want.entry_length ||
              got.verdict_valid !== want.verdict_valid ||
              got.access_granted !== want.access_granted) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected row=%b key=%b char=%h len=%0d ",
                        "verdict=%b grant=%b, got row=%b key=%b char=%h len=%0d ",
                        "verdict=%b grant=%b"},
                       want.row_drive, want.key_valid, want.key_char, want.entry_length,
                       want.verdict_valid, want.access_granted,
                       got.row_drive, got.key_valid, got.key_char, got.entry_length,
                       got.verdict_valid, got.access_granted);
          end
        end
      end
      // Register writes must only be made while no result is owed; the checker does not enforce this.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEBOUNCE) debounce_q = cfg_data[15:0];
        else passcode_q = cfg_data;
      end
      if (tick_valid && tick_ready) expected_results.push_back(scan_tick(tick_data[3:0]));
    end
    results_owed = expected_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the keypad_scan_code_lock_core bench: clock, reset, scan stimulus and the verdict.
// Depends on kscl_pkg, the core itself and keypad_lock_checker, which does the prediction.
module tb_top;
  import kscl_pkg::*;

  localparam int LIMIT        = 600000;
  localparam int RANDOM_TICKS = 1650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DEBOUNCE;
  logic [31:0] cfg_data = 32'd0;

  int          cycles = 0;
  int          ticks_sent = 0;
  int          mismatches;
  int          results_owed;
  int          debounce_now = DEBOUNCE_RESET;
  int          debounce_prev = 0;
  logic        calm = 1'b0;
  logic [2:0]  last_length = 3'd0;
  result_t     out_view;

  keypad_scan_code_lock_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  keypad_lock_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (s_axis_tvalid),
    .tick_ready   (s_axis_tready),
    .tick_data    (s_axis_tdata),
    .result_valid (m_axis_tvalid),
    .result_ready (m_axis_tready),
    .result_data  (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always #10 clk = ~clk;

  // Hard stop in case the core hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("keypad_scan_code_lock_core verification failed");
      $finish;
    end
  end

  // The receiver stalls now and then, except in calm phases.
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // Entry length after the latest result, used to line attempts up with whole codes.
  assign out_view = m_axis_tdata[$bits(result_t)-1:0];
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) last_length <= out_view.entry_length;
  end

  // Send one scan tick, with an occasional idle gap in front of it.
  task automatic send_tick(input logic [3:0] cols);
    while (!calm && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, cols};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Columns for a press on column col: lower columns open, higher ones random.
  function automatic logic [3:0] press_pattern(input int col);
    logic [3:0] cols;
    cols = 4'($urandom);
    for (int i = 0; i < 4; i++) begin
      if (i < col) cols[i] = 1'b1;
    end
    cols[col] = 1'b0;
    return cols;
  endfunction

  // Press and release one key, starting from row one while scanning.
  task automatic press_key(input int key_idx, input logic [3:0] press_cols,
                           input int laps, input int holds);
    int         col;
    logic [3:0] cols;
    col = key_idx % 4;
    repeat (key_idx / 4 + 4 * laps) send_tick(4'hF);
    send_tick(press_cols);
    // The debounce wait ignores the columns, so they carry noise.
    repeat (debounce_now) send_tick(4'($urandom));
    repeat (holds) begin
      cols = 4'($urandom);
      cols[col] = 1'b0;
      send_tick(cols);
    end
    cols = 4'($urandom);
    cols[col] = 1'b1;
    send_tick(cols);
  endtask

  // Bring the scanner back to row one from any state, at the cost of a key or two.
  task automatic resync_scan();
    repeat (debounce_prev + 2) send_tick(4'hF);
    repeat (debounce_now + 2) send_tick(4'h0);
    send_tick(4'hF);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  // One register write transaction.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          phase_no;
    int          code_idx [4];
    int          key;
    int          attempt;
    int          slip;
    int          fill;
    logic        usable;
    logic [31:0] passcode_now;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with zero debounce: the reset passcode, all columns low, priority.
    debounce_now = 0;
    write_reg(CFG_DEBOUNCE, 32'h0000_0000);
    press_key(0, 4'b1110, 0, 0);
    press_key(1, 4'b1101, 0, 0);
    press_key(2, 4'b1011, 0, 0);
    press_key(4, 4'b1110, 0, 0);
    press_key(12, 4'b0000, 0, 1);
    press_key(15, 4'b0111, 0, 0);
    press_key(14, 4'b0011, 0, 0);

    // Random phases, each with its own register settings.
    phase_no = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      drain_results();
      calm <= (phase_no % 5 == 2);
      debounce_prev = debounce_now;
      case (phase_no % 6)
        0:       debounce_now = 0;
        1:       debounce_now = 1;
        2:       debounce_now = 2;
        3:       debounce_now = DEBOUNCE_RESET;
        default: debounce_now = $urandom_range(0, 6);
      endcase
      write_reg(CFG_DEBOUNCE, {16'($urandom), 16'(debounce_now)});
      passcode_now = 32'd0;
      usable = 1'b0;
      case (phase_no % 5)
        0: begin
          passcode_now = PASSCODE_RESET;
          code_idx = '{0, 1, 2, 4};
          usable = 1'b1;
        end
        1: passcode_now = $urandom;
        3: passcode_now = 32'h0000_0000;
        4: passcode_now = 32'hFFFF_FFFF;
        default: begin
          for (int k = 0; k < 4; k++) begin
            code_idx[k] = $urandom_range(0, 15);
            passcode_now = {passcode_now[23:0], 1'b0, key_ascii(4'(code_idx[k]))};
          end
          usable = 1'b1;
        end
      endcase
      write_reg(CFG_PASSCODE, passcode_now);

      // Known state first, then pad the entry so attempts start on a fresh code.
      resync_scan();
      drain_results();
      fill = (4 - int'(last_length)) % 4;
      repeat (fill) begin
        key = $urandom_range(0, 15);
        press_key(key, press_pattern(key % 4), 0, $urandom_range(0, 2));
      end

      // Code attempts: the right code, one wrong key, or random keys.
      repeat ($urandom_range(4, 8)) begin
        attempt = $urandom_range(0, 3);
        slip = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          if (usable && attempt < 2) key = code_idx[k];
          else if (usable && attempt == 2 && k != slip) key = code_idx[k];
          else key = $urandom_range(0, 15);
          press_key(key, press_pattern(key % 4),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0,
                    ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4));
        end
      end

      // Raw column noise, which may leave a wait running into the next write.
      repeat ($urandom_range(6, 20)) send_tick(4'($urandom));
      phase_no++;
    end

    // Longest debounce wait: started and counted down for a stretch.
    drain_results();
    calm <= 1'b0;
    debounce_prev = debounce_now;
    debounce_now = 65535;
    write_reg(CFG_DEBOUNCE, 32'h0000_FFFF);
    repeat (debounce_prev + 6) send_tick(4'hF);
    repeat (40) send_tick(4'($urandom));

    drain_results();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("keypad_scan_code_lock_core verification clean");
    end else begin
      $display("keypad_scan_code_lock_core verification failed");
    end
    $finish;
  end

endmodule
